>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/b64v_pkg.sv
package b64v_pkg;

    localparam logic [5:0] SEXTET_MASK = 6'h3F;
    localparam logic [7:0] PAD_CHAR    = 8'h5B;  // '['
    localparam logic [7:0] CHAR_62     = 8'h2A;  // '*'
    localparam logic [7:0] CHAR_63     = 8'h2D;  // '-'
    localparam logic [1:0] LAST_IDX    = 2'd3;

    // One 24-bit group with the number of real characters (2..4) and end flag.
    typedef struct packed {
        logic [23:0] bits;
        logic [2:0]  n_chars;
        logic        fin;
    } group_t;

    // Emitter state seen by the top level.
    typedef struct packed {
        logic       slot_valid;
        logic [1:0] idx;
    } emit_status_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] ch;
        case (v & SEXTET_MASK) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         ch = CHAR_62;
            default:       ch = CHAR_63;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/b64v_pack.sv
module b64v_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output logic                grp_valid,
    input  logic                grp_ready,
    output b64v_pkg::group_t    grp
);

    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        closes;
    logic        accept;

    // Third byte or final byte closes a group.
    assign closes     = held_count_reg[1] || final_byte;
    assign grp_valid  = byte_valid && closes;
    assign byte_stall = closes && !grp_ready;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        grp = '0;
        grp.fin = final_byte;
        if (held_count_reg[1])
        begin
            grp.bits    = {held_bytes_reg, data_byte};
            grp.n_chars = 3'd4;
        end
        else if (held_count_reg[0])
        begin
            grp.bits    = {held_bytes_reg[7:0], data_byte, 8'h00};
            grp.n_chars = 3'd3;
        end
        else
        begin
            grp.bits    = {data_byte, 16'h0000};
            grp.n_chars = 3'd2;
        end
    end

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (closes)
            begin
                held_bytes_next = '0;
                held_count_next = '0;
            end
            else
            begin
                held_bytes_next = {held_bytes_reg[7:0], data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

>>> rtl/b64v_emit.sv
module b64v_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   grp_valid,
    output logic                   grp_ready,
    input  b64v_pkg::group_t       grp,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [7:0]             code_char,
    output logic                   group_end,
    output logic                   message_end,
    output b64v_pkg::emit_status_t status
);

    logic              slot_valid_reg;
    logic [1:0]        idx_reg;
    b64v_pkg::group_t  slot_reg;
    logic              out_valid_reg;
    logic [7:0]        char_reg;
    logic              gend_reg;
    logic              mend_reg;
    logic              load_out;
    logic              last_char;
    logic [5:0]        sextet;
    logic [7:0]        char_next;

    assign load_out  = slot_valid_reg && (!out_valid_reg || !char_stall);
    assign last_char = (idx_reg == b64v_pkg::LAST_IDX);
    // Take the next group while the last character of this one leaves.
    assign grp_ready = !slot_valid_reg || (load_out && last_char);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = slot_reg.bits[23:18];
            2'd1:    sextet = slot_reg.bits[17:12];
            2'd2:    sextet = slot_reg.bits[11:6];
            default: sextet = slot_reg.bits[5:0];
        endcase
        if ({1'b0, idx_reg} < slot_reg.n_chars)
            char_next = b64v_pkg::sextet_char(sextet);
        else
            char_next = b64v_pkg::PAD_CHAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
                idx_reg <= idx_reg + 2'd1;
            if (grp_valid && grp_ready)
                slot_valid_reg <= 1'b1;
            else if (load_out && last_char)
                slot_valid_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!char_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_valid && grp_ready)
            slot_reg <= grp;
        if (load_out)
        begin
            char_reg <= char_next;
            gend_reg <= last_char;
            mend_reg <= last_char && slot_reg.fin;
        end
    end

    assign char_valid        = out_valid_reg;
    assign code_char         = char_reg;
    assign group_end         = gend_reg;
    assign message_end       = mend_reg;
    assign status.slot_valid = slot_valid_reg;
    assign status.idx        = idx_reg;

endmodule

>>> rtl/base64_variant_encoder.sv
// Channel   Handshake               Payload
// --------  ----------------------  ----------------------------------------
// byte in   byte_valid/byte_stall   data_byte[7:0], final_byte
// char out  char_valid/char_stall   code_char[7:0], group_end, message_end
//
// On the byte side, a byte that is only held is never stalled.
// A closing byte waits for a free group slot, freed on the cycle the fourth character of
// the previous group moves into the output register; its first character then follows from the slot.
// One character leaves per cycle unless char_stall holds it; three bytes make four characters.
// rst_n is asynchronous and clears held count, group slot and output valid.
// A stalled output holds its character and the slot; the byte side only keeps holding bytes.
`include "assert_macros.svh"

module base64_variant_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [7:0] code_char,
    output logic       group_end,
    output logic       message_end
);

    logic                   grp_valid;
    logic                   grp_ready;
    b64v_pkg::group_t       grp;
    b64v_pkg::emit_status_t emit_status;

    // Hold bytes and form a 24-bit group on the closing byte.
    b64v_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .grp_valid  (grp_valid),
        .grp_ready  (grp_ready),
        .grp        (grp)
    );

    // Map the group to four characters, one per cycle unless stalled, via the output register.
    b64v_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready),
        .grp         (grp),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .code_char   (code_char),
        .group_end   (group_end),
        .message_end (message_end),
        .status      (emit_status)
    );

    // A partly sent group always still occupies the slot.
    `ASSERT_IMP(a_idx_in_slot, clk, rst_n, emit_status.idx != 2'd0, emit_status.slot_valid)
    // An accepted closing byte fills the slot.
    `ASSERT_NEXT(a_group_loaded, clk, rst_n, byte_valid && !byte_stall && grp_valid, emit_status.slot_valid)
    // The message end only comes on the last character of a group.
    `ASSERT_IMP(a_mend_on_gend, clk, rst_n, char_valid && message_end, group_end)

endmodule

>>> tb/sv/b64v_stream_checker.sv
module b64v_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       char_valid,
    input  logic       char_stall,
    input  logic [7:0] code_char,
    input  logic       group_end,
    input  logic       message_end,
    input  logic       wrap_up,
    output int         char_errors,
    output int         chars_owed
);

    typedef struct packed {
        logic [7:0] ascii;
        logic       gend;
        logic       mend;
    } b64_char_t;

    b64_char_t   awaited_chars[$];
    logic [15:0] held_bits = '0;
    logic [1:0]  held_n = '0;
    bit          tallied = 1'b0;

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        char_errors++;
    endtask

    // map one 6-bit value onto the variant alphabet
    function automatic logic [7:0] letter_of(input logic [5:0] s);
        if (s < 6'd26)
            return 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            return 8'h61 + {2'b00, s} - 8'd26;
        else if (s < 6'd62)
            return 8'h30 + {2'b00, s} - 8'd52;
        else if (s == 6'd62)
            return b64v_pkg::CHAR_62;
        else
            return b64v_pkg::CHAR_63;
    endfunction

    // hold the byte, or close the group and queue its four characters
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        int          n_real;
        int          k;
        b64_char_t   c;
        if (held_n >= 2'd2)
        begin
            grp = {held_bits, b};
            n_real = 4;
        end
        else if (fin)
        begin
            if (held_n == 2'd1)
            begin
                grp = {held_bits[7:0], b, 8'h00};
                n_real = 3;
            end
            else
            begin
                grp = {b, 16'h0000};
                n_real = 2;
            end
        end
        else
        begin
            held_bits = {held_bits[7:0], b};
            held_n = held_n + 2'd1;
            return;
        end
        for (k = 0; k < 4; k++)
        begin
            if (k < n_real)
                c.ascii = letter_of(6'((grp >> (18 - 6 * k)) & 24'h3F));
            else
                c.ascii = b64v_pkg::PAD_CHAR;
            c.gend = (k == 3);
            c.mend = (k == 3) && fin;
            awaited_chars = {awaited_chars, c};
        end
        held_bits = '0;
        held_n = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        b64_char_t want;
        if (!rst_n)
        begin
            awaited_chars.delete();
            held_bits = '0;
            held_n = '0;
            char_errors = 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                absorb_byte(data_byte, final_byte);
            if (char_valid && !char_stall)
            begin
                if (awaited_chars.size() == 0)
                    note_mismatch($sformatf("unexpected character 0x%02h", code_char));
                else
                begin
                    want = awaited_chars.pop_front();
                    if (code_char !== want.ascii)
                        note_mismatch($sformatf("code_char 0x%02h, want 0x%02h",
                                                code_char, want.ascii));
                    if (group_end !== want.gend)
                        note_mismatch($sformatf("group_end %b, want %b",
                                                group_end, want.gend));
                    if (message_end !== want.mend)
                        note_mismatch($sformatf("message_end %b, want %b",
                                                message_end, want.mend));
                end
            end
            if (wrap_up && !tallied)
            begin
                tallied = 1'b1;
                if (awaited_chars.size() != 0)
                    note_mismatch($sformatf("%0d characters never arrived",
                                            awaited_chars.size()));
            end
        end
        chars_owed = awaited_chars.size();
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;

    localparam int MSG_BYTES   = 310;  // start no new message after this many bytes
    localparam int CALM_AFTER  = 250;  // no idling on either side past this
    localparam int SQUEEZE_AT  = 60;   // start of the long output hold-off
    localparam int SQUEEZE_LEN = 150;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] code_char;
    logic       group_end;
    logic       message_end;
    logic       wrap_up;

    int char_errors;
    int chars_owed;
    int n_sent = 0;
    int cycles = 0;
    bit calm = 1'b0;

    always #6 clk = ~clk;

    base64_variant_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .code_char  (code_char),
        .group_end  (group_end),
        .message_end(message_end)
    );

    // The checker snoops both channels, predicts every character and
    // compares; all this module needs back is the error and owed counts.
    b64v_stream_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .code_char  (code_char),
        .group_end  (group_end),
        .message_end(message_end),
        .wrap_up    (wrap_up),
        .char_errors(char_errors),
        .chars_owed (chars_owed)
    );

    // Watchdog: abort if the run hangs anywhere.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one byte request and return at the edge that takes it. Valid
    // stays high into the next request unless a gap is drawn, so it is never
    // dropped and raised within one step. Outside the calm tail, drop valid
    // now and then before the request.
    task automatic put_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        n_sent++;
        if (n_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // Output side: random stall bursts, more frequent stall-free runs, and one long
    // hold-off so the group slot and output register fill up and the byte
    // side gets stalled. No stalls once the calm tail starts.
    initial
    begin : sink
        int  run;
        bit  squeezed;
        squeezed = 1'b0;
        char_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!squeezed && n_sent >= SQUEEZE_AT)
            begin
                squeezed = 1'b1;
                char_stall <= 1'b1;
                repeat (SQUEEZE_LEN) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                char_stall <= 1'b0;
                run = $urandom_range(1, 11);
                repeat (run) @(posedge clk);
            end
            else
            begin
                char_stall <= 1'b1;
                run = $urandom_range(1, 11);
                repeat (run) @(posedge clk);
            end
        end
    end

    initial
    begin : source
        int len;
        int i;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        data_byte  <= 8'h00;
        final_byte <= 1'b0;
        wrap_up    <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages: one-byte and two-byte tails with padding, a
        // full group that is also final, all-zero and all-one bytes, the
        // two symbol characters, and a group followed by a one-byte tail.
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFB, 1'b0);
        put_byte(8'hEF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h10, 1'b0);
        put_byte(8'h83, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hF8, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h3E, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b0);
        put_byte(8'h03, 1'b0);
        put_byte(8'h04, 1'b1);

        // Random messages: mostly short, now and then a long one, so the
        // tail length cycles through all three cases.
        while (n_sent < MSG_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(20, 40);
            else
                len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                put_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
        byte_valid <= 1'b0;

        // Drain: wait for every owed character, then give the block a few
        // more cycles to show any extra output before closing the books.
        while (chars_owed != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);

        if (char_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
